// ===== hdl/p0sm_pkg.sv =====
package p0sm_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int PC_W        = 16;
    localparam int DATA_W      = 32;
    localparam int EXT_W       = DATA_W + 2;
    localparam int IN_W        = 80;
    localparam int OUT_W       = 56;

    localparam logic signed [EXT_W-1:0] DEPTH_X = EXT_W'(STACK_DEPTH);

    typedef enum logic [3:0] {
        CMD_LIT = 4'd0,
        CMD_OPR = 4'd1,
        CMD_LOD = 4'd2,
        CMD_STO = 4'd3,
        CMD_CAL = 4'd4,
        CMD_INC = 4'd5,
        CMD_JMP = 4'd6,
        CMD_JPC = 4'd7,
        CMD_SIO = 4'd8,
        CMD_LDA = 4'd9,
        CMD_STA = 4'd10,
        CMD_DEC = 4'd11
    } cmd_t;

    localparam logic [DATA_W-1:0] OPR_RET = 32'd0;
    localparam logic [DATA_W-1:0] OPR_NEG = 32'd1;
    localparam logic [DATA_W-1:0] OPR_ADD = 32'd2;
    localparam logic [DATA_W-1:0] OPR_SUB = 32'd3;
    localparam logic [DATA_W-1:0] OPR_MUL = 32'd4;
    localparam logic [DATA_W-1:0] OPR_DIV = 32'd5;
    localparam logic [DATA_W-1:0] OPR_ODD = 32'd6;
    localparam logic [DATA_W-1:0] OPR_MOD = 32'd7;
    localparam logic [DATA_W-1:0] OPR_EQ  = 32'd8;
    localparam logic [DATA_W-1:0] OPR_NE  = 32'd9;
    localparam logic [DATA_W-1:0] OPR_LT  = 32'd10;
    localparam logic [DATA_W-1:0] OPR_LE  = 32'd11;
    localparam logic [DATA_W-1:0] OPR_GT  = 32'd12;
    localparam logic [DATA_W-1:0] OPR_GE  = 32'd13;

    localparam logic [DATA_W-1:0] IO_WRITE = 32'd0;
    localparam logic [DATA_W-1:0] IO_READ  = 32'd1;
    localparam logic [DATA_W-1:0] IO_HALT  = 32'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_STACK = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;
    localparam logic [1:0] ERR_OVF   = 2'd3;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

    function automatic logic signed [EXT_W-1:0] sext(input logic [DATA_W-1:0] v);
        return signed'({{(EXT_W-DATA_W){v[DATA_W-1]}}, v});
    endfunction

    function automatic logic signed [EXT_W-1:0] uext(input logic [ADDR_W-1:0] a);
        return signed'({{(EXT_W-ADDR_W){1'b0}}, a});
    endfunction

    function automatic logic in_rng(input logic signed [EXT_W-1:0] a);
        return !a[EXT_W-1] && (a < DEPTH_X);
    endfunction

endpackage

// ===== hdl/p0sm_ram.sv =====
module p0sm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/p0sm_div.sv =====
module p0sm_div
    import p0sm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctl_t          ctl_in,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output div_ctl_t          ctl_out,
    output logic [DATA_W-1:0] quotient,
    output logic [DATA_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_W);

    logic [DATA_W:0]    rem_reg;
    logic [DATA_W-1:0]  quo_reg;
    logic [DATA_W-1:0]  den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               neg_q_reg;
    logic               neg_r_reg;
    logic [DATA_W:0]    rem_sh;
    logic [DATA_W:0]    diff;
    logic [DATA_W-1:0]  mag_a;
    logic [DATA_W-1:0]  mag_b;

    assign mag_a  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
    assign rem_sh = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            rem_reg   <= '0;
            quo_reg   <= mag_a;
            den_reg   <= mag_b;
            neg_q_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_reg <= dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign ctl_out.start = busy_reg;
    assign ctl_out.done  = done_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg[DATA_W-1:0] + 1'b1) : rem_reg[DATA_W-1:0];

endmodule

// ===== hdl/pl0_stack_machine.sv =====
// Items walk the static links level by level (ST_WALK_RD, ST_WALK_WT); DIV/MOD
// wait in ST_DIV for the shift-subtract divider, MUL passes through ST_MUL.
// Throughput: one item at a time; every stack read goes through the single
// read port of the stack RAM; a result not yet taken holds back the next one.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the
// stack RAM, one word per cycle, with s_tready low.
module pl0_stack_machine
    import p0sm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // command[3:0], level[11:4], operand[43:12], read_value[75:44], zeros
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // next_pc[15:0], write_valid[16], write_value[48:17], halted[49],
    // fault_code[51:50], zeros
    output logic [OUT_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_WT,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]   top_reg, top_next;
    logic [ADDR_W-1:0]   fp_reg, fp_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic                stopped_reg, stopped_next;
    logic [1:0]          fault_reg, fault_next;
    logic [1:0]          step_reg, step_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    cmd_t                cmd_reg, cmd_next;
    logic [DATA_W-1:0]   opd_reg, opd_next;
    logic [DATA_W-1:0]   rdv_reg, rdv_next;
    logic [DATA_W-1:0]   cur_reg, cur_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic                res_wv_reg, res_wv_next;
    logic [DATA_W-1:0]   res_wval_reg, res_wval_next;
    logic [OUT_W-1:0]    out_reg, out_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
    logic [DATA_W-1:0]   rdata;

    div_ctl_t            div_in, div_out;
    logic [DATA_W-1:0]   quot;
    logic [DATA_W-1:0]   remd;

    logic                fail;
    logic [1:0]          fail_code;
    logic                finish;

    logic signed [EXT_W-1:0] tx, fx, mx, bx, rx, vx, addr_m, addr_r, sum_xy;
    logic [PC_W-1:0]         npc;

    assign tx     = uext(top_reg);
    assign fx     = uext(fp_reg);
    assign mx     = sext(opd_reg);
    assign bx     = sext(cur_reg);
    assign rx     = sext(rdata);
    assign vx     = sext(val_reg);
    assign addr_m = bx + mx;
    assign addr_r = bx + rx;
    assign sum_xy = rx + vx;
    assign npc    = pc_reg + 1'b1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    p0sm_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    p0sm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (div_in),
        .dividend  (rdata),
        .divisor   (val_reg),
        .ctl_out   (div_out),
        .quotient  (quot),
        .remainder (remd)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        top_next       = top_reg;
        fp_next        = fp_reg;
        pc_next        = pc_reg;
        stopped_next   = stopped_reg;
        fault_next     = fault_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        opd_next       = opd_reg;
        rdv_next       = rdv_reg;
        cur_next       = cur_reg;
        val_next       = val_reg;
        addr_next      = addr_reg;
        prod_next      = prod_reg;
        res_wv_next    = res_wv_reg;
        res_wval_next  = res_wval_reg;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = top_reg;
        wdata          = '0;
        raddr          = top_reg;
        div_in.start   = 1'b0;
        div_in.done    = 1'b0;
        fail           = 1'b0;
        fail_code      = ERR_STACK;
        finish         = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(STACK_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next      = cmd_t'(s_tdata[3:0]);
                    cnt_next      = s_tdata[11:4];
                    opd_next      = s_tdata[43:12];
                    rdv_next      = s_tdata[75:44];
                    cur_next      = {{(DATA_W-ADDR_W){1'b0}}, fp_reg};
                    step_next     = '0;
                    res_wv_next   = 1'b0;
                    res_wval_next = '0;
                    if (stopped_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        case (cmd_t'(s_tdata[3:0])) inside
                            CMD_LOD, CMD_STO, CMD_CAL, CMD_LDA, CMD_STA:
                                state_next = ST_WALK_RD;
                            default:
                                state_next = ST_EXEC;
                        endcase
                    end
                end
            end

            ST_WALK_RD:
            begin
                raddr = ADDR_W'(bx + 1);
                if (cnt_reg == 8'd0)
                begin
                    state_next = ST_EXEC;
                end
                else if (!in_rng(bx + 1))
                begin
                    fail = 1'b1;
                end
                else
                begin
                    state_next = ST_WALK_WT;
                end
            end

            ST_WALK_WT:
            begin
                cur_next   = rdata;
                cnt_next   = cnt_reg - 1'b1;
                state_next = ST_WALK_RD;
            end

            ST_EXEC:
            begin
                step_next = step_reg + 1'b1;
                unique case (cmd_reg)
                    CMD_LIT:
                    begin
                        if (!in_rng(tx + 1))
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            we       = 1'b1;
                            waddr    = top_reg + 1'b1;
                            wdata    = opd_reg;
                            top_next = top_reg + 1'b1;
                            finish   = 1'b1;
                        end
                    end

                    CMD_OPR:
                    begin
                        case (opd_reg) inside
                            OPR_RET:
                            begin
                                if (step_reg == 2'd0)
                                begin
                                    raddr = fp_reg + ADDR_W'(2);
                                    if (fp_reg == '0 || !in_rng(fx + 3))
                                    begin
                                        fail = 1'b1;
                                    end
                                end
                                else if (step_reg == 2'd1)
                                begin
                                    raddr    = fp_reg + ADDR_W'(3);
                                    val_next = rdata;
                                end
                                else
                                begin
                                    if (!in_rng(vx))
                                    begin
                                        fail = 1'b1;
                                    end
                                    else
                                    begin
                                        pc_next    = rdata[PC_W-1:0];
                                        top_next   = fp_reg - 1'b1;
                                        fp_next    = val_reg[ADDR_W-1:0];
                                        state_next = ST_DONE;
                                        if (val_reg == '0)
                                        begin
                                            stopped_next = 1'b1;
                                        end
                                    end
                                end
                            end

                            OPR_NEG, OPR_ODD:
                            begin
                                if (step_reg != 2'd0)
                                begin
                                    we     = 1'b1;
                                    waddr  = top_reg;
                                    wdata  = (opd_reg == OPR_NEG) ? (~rdata + 1'b1)
                                                                  : {31'd0, rdata[0]};
                                    finish = 1'b1;
                                end
                            end

                            OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_MOD, OPR_EQ,
                            OPR_NE, OPR_LT, OPR_LE, OPR_GT, OPR_GE:
                            begin
                                if (step_reg == 2'd0)
                                begin
                                    if (top_reg == '0)
                                    begin
                                        fail = 1'b1;
                                    end
                                end
                                else if (step_reg == 2'd1)
                                begin
                                    raddr    = top_reg - 1'b1;
                                    val_next = rdata;
                                end
                                else
                                begin
                                    waddr    = top_reg - 1'b1;
                                    top_next = top_reg - 1'b1;
                                    we       = 1'b1;
                                    finish   = 1'b1;
                                    case (opd_reg)
                                        OPR_ADD:
                                        begin
                                            wdata = sum_xy[DATA_W-1:0];
                                            if (sum_xy[DATA_W] != sum_xy[DATA_W-1])
                                            begin
                                                fail      = 1'b1;
                                                fail_code = ERR_OVF;
                                            end
                                        end
                                        OPR_SUB: wdata = rdata - val_reg;
                                        OPR_MUL:
                                        begin
                                            we         = 1'b0;
                                            finish     = 1'b0;
                                            top_next   = top_reg;
                                            prod_next  = $signed(rdata) * $signed(val_reg);
                                            state_next = ST_MUL;
                                        end
                                        OPR_DIV, OPR_MOD:
                                        begin
                                            we       = 1'b0;
                                            finish   = 1'b0;
                                            top_next = top_reg;
                                            if (val_reg == '0)
                                            begin
                                                fail      = 1'b1;
                                                fail_code = ERR_DIV0;
                                            end
                                            else
                                            begin
                                                div_in.start = 1'b1;
                                                state_next   = ST_DIV;
                                            end
                                        end
                                        OPR_EQ:  wdata = {31'd0, rx == vx};
                                        OPR_NE:  wdata = {31'd0, rx != vx};
                                        OPR_LT:  wdata = {31'd0, rx < vx};
                                        OPR_LE:  wdata = {31'd0, rx <= vx};
                                        OPR_GT:  wdata = {31'd0, rx > vx};
                                        default: wdata = {31'd0, rx >= vx};
                                    endcase
                                end
                            end

                            default:
                                finish = 1'b1;
                        endcase
                    end

                    CMD_LOD:
                    begin
                        raddr = addr_m[ADDR_W-1:0];
                        if (step_reg == 2'd0)
                        begin
                            if (!in_rng(tx + 1) || !in_rng(addr_m))
                            begin
                                fail = 1'b1;
                            end
                        end
                        else
                        begin
                            we       = 1'b1;
                            waddr    = top_reg + 1'b1;
                            wdata    = rdata;
                            top_next = top_reg + 1'b1;
                            finish   = 1'b1;
                        end
                    end

                    CMD_STO:
                    begin
                        if (step_reg == 2'd0)
                        begin
                            if (top_reg == '0 || !in_rng(addr_m))
                            begin
                                fail = 1'b1;
                            end
                        end
                        else
                        begin
                            we       = 1'b1;
                            waddr    = addr_m[ADDR_W-1:0];
                            wdata    = rdata;
                            top_next = top_reg - 1'b1;
                            finish   = 1'b1;
                        end
                    end

                    CMD_CAL:
                    begin
                        waddr = top_reg + ADDR_W'(step_reg) + 1'b1;
                        if (step_reg == 2'd0 && !in_rng(tx + 4))
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            we = 1'b1;
                            case (step_reg)
                                2'd0:    wdata = '0;
                                2'd1:    wdata = cur_reg;
                                2'd2:    wdata = {{(DATA_W-ADDR_W){1'b0}}, fp_reg};
                                default:
                                begin
                                    wdata      = {{(DATA_W-PC_W){1'b0}}, npc};
                                    fp_next    = top_reg + 1'b1;
                                    pc_next    = opd_reg[PC_W-1:0];
                                    state_next = ST_DONE;
                                end
                            endcase
                        end
                    end

                    CMD_INC, CMD_DEC:
                    begin
                        if (!in_rng((cmd_reg == CMD_INC) ? (tx + mx) : (tx - mx)))
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            top_next = (cmd_reg == CMD_INC) ? ADDR_W'(tx + mx)
                                                            : ADDR_W'(tx - mx);
                            finish   = 1'b1;
                        end
                    end

                    CMD_JMP:
                    begin
                        pc_next    = opd_reg[PC_W-1:0];
                        state_next = ST_DONE;
                    end

                    CMD_JPC:
                    begin
                        if (step_reg == 2'd0)
                        begin
                            if (top_reg == '0)
                            begin
                                fail = 1'b1;
                            end
                        end
                        else
                        begin
                            top_next   = top_reg - 1'b1;
                            pc_next    = (rdata == '0) ? opd_reg[PC_W-1:0] : npc;
                            state_next = ST_DONE;
                        end
                    end

                    CMD_SIO:
                    begin
                        case (opd_reg)
                            IO_WRITE:
                            begin
                                if (step_reg == 2'd0)
                                begin
                                    if (top_reg == '0)
                                    begin
                                        fail = 1'b1;
                                    end
                                end
                                else
                                begin
                                    res_wv_next   = 1'b1;
                                    res_wval_next = rdata;
                                    top_next      = top_reg - 1'b1;
                                    finish        = 1'b1;
                                end
                            end
                            IO_READ:
                            begin
                                if (!in_rng(tx + 1))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    we       = 1'b1;
                                    waddr    = top_reg + 1'b1;
                                    wdata    = rdv_reg;
                                    top_next = top_reg + 1'b1;
                                    finish   = 1'b1;
                                end
                            end
                            IO_HALT:
                            begin
                                stopped_next = 1'b1;
                                finish       = 1'b1;
                            end
                            default:
                                finish = 1'b1;
                        endcase
                    end

                    CMD_LDA, CMD_STA:
                    begin
                        if (step_reg == 2'd0)
                        begin
                            raddr = (cmd_reg == CMD_STA) ? (top_reg - 1'b1) : top_reg;
                            if (cmd_reg == CMD_STA && top_reg < ADDR_W'(2))
                            begin
                                fail = 1'b1;
                            end
                        end
                        else if (step_reg == 2'd1)
                        begin
                            addr_next = addr_r[ADDR_W-1:0];
                            raddr     = (cmd_reg == CMD_STA) ? top_reg : addr_r[ADDR_W-1:0];
                            if (addr_r[EXT_W-1] || addr_r > tx)
                            begin
                                fail = 1'b1;
                            end
                        end
                        else
                        begin
                            we     = 1'b1;
                            wdata  = rdata;
                            finish = 1'b1;
                            if (cmd_reg == CMD_STA)
                            begin
                                waddr    = addr_reg;
                                top_next = top_reg - ADDR_W'(2);
                            end
                            else
                            begin
                                waddr = top_reg;
                            end
                        end
                    end

                    default:
                        finish = 1'b1;
                endcase
            end

            ST_MUL:
            begin
                if (prod_reg[63:DATA_W-1] != {(65-DATA_W){prod_reg[DATA_W-1]}})
                begin
                    fail      = 1'b1;
                    fail_code = ERR_OVF;
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = top_reg - 1'b1;
                    wdata    = prod_reg[DATA_W-1:0];
                    top_next = top_reg - 1'b1;
                    finish   = 1'b1;
                end
            end

            ST_DIV:
            begin
                if (div_out.done)
                begin
                    we       = 1'b1;
                    waddr    = top_reg - 1'b1;
                    wdata    = (opd_reg == OPR_DIV) ? quot : remd;
                    top_next = top_reg - 1'b1;
                    finish   = 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = {4'd0, fault_reg, stopped_reg, res_wval_reg,
                                      res_wv_reg, pc_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        if (finish)
        begin
            pc_next    = npc;
            state_next = ST_DONE;
        end

        if (fail)
        begin
            we            = 1'b0;
            div_in.start  = 1'b0;
            top_next      = top_reg;
            fp_next       = fp_reg;
            pc_next       = pc_reg;
            res_wv_next   = 1'b0;
            res_wval_next = '0;
            stopped_next  = 1'b1;
            fault_next    = fail_code;
            state_next    = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            top_reg       <= '0;
            fp_reg        <= ADDR_W'(1);
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            fault_reg     <= ERR_NONE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            top_reg       <= top_next;
            fp_reg        <= fp_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            fault_reg     <= fault_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        opd_reg      <= opd_next;
        rdv_reg      <= rdv_next;
        cur_reg      <= cur_next;
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        prod_reg     <= prod_next;
        res_wv_reg   <= res_wv_next;
        res_wval_reg <= res_wval_next;
        out_reg      <= out_next;
    end

endmodule

// ===== tb/sv/pl0_stack_machine_chk.sv =====
`timescale 1ns / 100ps

module pl0_stack_machine_chk
    import p0sm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               errors,
    output int               pending
);

    // most significant member first: matches m_tdata[51:0]
    typedef struct packed {
        logic [1:0]  fault_code;
        logic        halted;
        logic [31:0] write_value;
        logic        write_valid;
        logic [15:0] next_pc;
    } status_t;

    status_t     status_q[$];
    logic [31:0] mem [STACK_DEPTH];
    longint      tos;
    longint      fp_q;
    logic [15:0] pc;
    logic        halt_q;
    logic [1:0]  err_q;

    function automatic longint sx(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic bit ok(input longint a);
        return a >= 0 && a < STACK_DEPTH;
    endfunction

    function automatic bit walk(input int lev, output longint b);
        longint cur;
        cur = fp_q;
        for (int i = 0; i < lev; i++)
        begin
            if (!ok(cur + 1))
                return 0;
            cur = sx(mem[cur + 1]);
        end
        b = cur;
        return 1;
    endfunction

    task automatic exec_instr(input logic [IN_W-1:0] d);
        logic [3:0]  cmd;
        int          lev;
        logic [31:0] opu;
        logic [31:0] rdv;
        longint      m;
        longint      top;
        longint      b;
        longint      addr;
        longint      x;
        longint      y;
        longint      r;
        longint      nfp;
        logic [15:0] npc;
        bit          flt;
        logic [1:0]  code;
        status_t     st;
        cmd  = d[3:0];
        lev  = d[11:4];
        opu  = d[43:12];
        rdv  = d[75:44];
        m    = sx(opu);
        top  = tos;
        npc  = pc + 16'd1;
        flt  = 0;
        code = ERR_STACK;
        st   = '0;
        if (!halt_q)
        begin
            case (cmd)
                CMD_LIT:
                    if (!ok(top + 1)) flt = 1;
                    else
                    begin
                        mem[top + 1] = opu;
                        tos = top + 1;
                    end
                CMD_OPR:
                    case (opu)
                        OPR_RET:
                            if (fp_q < 1 || !ok(fp_q + 3)) flt = 1;
                            else
                            begin
                                nfp = sx(mem[fp_q + 2]);
                                if (!ok(nfp)) flt = 1;
                                else
                                begin
                                    npc  = mem[fp_q + 3][15:0];
                                    tos  = fp_q - 1;
                                    fp_q = nfp;
                                    if (nfp == 0) halt_q = 1;
                                end
                            end
                        OPR_NEG: mem[top] = 32'd0 - mem[top];
                        OPR_ODD: mem[top] = mem[top] & 32'd1;
                        OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_MOD, OPR_EQ, OPR_NE,
                        OPR_LT, OPR_LE, OPR_GT, OPR_GE:
                            if (top < 1) flt = 1;
                            else
                            begin
                                x = sx(mem[top - 1]);
                                y = sx(mem[top]);
                                r = 0;
                                case (opu)
                                    OPR_ADD: r = x + y;
                                    OPR_SUB: r = x - y;
                                    OPR_MUL: r = x * y;
                                    OPR_DIV: if (y != 0) r = x / y;
                                    OPR_MOD: if (y != 0) r = x % y;
                                    OPR_EQ:  r = x == y;
                                    OPR_NE:  r = x != y;
                                    OPR_LT:  r = x < y;
                                    OPR_LE:  r = x <= y;
                                    OPR_GT:  r = x > y;
                                    default: r = x >= y;
                                endcase
                                if ((opu == OPR_ADD || opu == OPR_MUL) &&
                                    (r < -64'sd2147483648 || r > 64'sd2147483647))
                                begin
                                    flt  = 1;
                                    code = ERR_OVF;
                                end
                                else if ((opu == OPR_DIV || opu == OPR_MOD) && y == 0)
                                begin
                                    flt  = 1;
                                    code = ERR_DIV0;
                                end
                                else
                                begin
                                    mem[top - 1] = r[31:0];
                                    tos = top - 1;
                                end
                            end
                        default: ;
                    endcase
                CMD_LOD:
                    if (!ok(top + 1) || !walk(lev, b) || !ok(b + m)) flt = 1;
                    else
                    begin
                        mem[top + 1] = mem[b + m];
                        tos = top + 1;
                    end
                CMD_STO:
                    if (top < 1 || !walk(lev, b) || !ok(b + m)) flt = 1;
                    else
                    begin
                        mem[b + m] = mem[top];
                        tos = top - 1;
                    end
                CMD_CAL:
                    if (!walk(lev, b) || !ok(top + 4)) flt = 1;
                    else
                    begin
                        mem[top + 1] = 32'd0;
                        mem[top + 2] = b[31:0];
                        mem[top + 3] = fp_q[31:0];
                        mem[top + 4] = {16'd0, npc};
                        fp_q = top + 1;
                        npc  = opu[15:0];
                    end
                CMD_INC:
                    if (!ok(top + m)) flt = 1;
                    else tos = top + m;
                CMD_JMP: npc = opu[15:0];
                CMD_JPC:
                    if (top < 1) flt = 1;
                    else
                    begin
                        if (mem[top] == 32'd0) npc = opu[15:0];
                        tos = top - 1;
                    end
                CMD_SIO:
                    case (opu)
                        IO_WRITE:
                            if (top < 1) flt = 1;
                            else
                            begin
                                st.write_valid = 1;
                                st.write_value = mem[top];
                                tos = top - 1;
                            end
                        IO_READ:
                            if (!ok(top + 1)) flt = 1;
                            else
                            begin
                                mem[top + 1] = rdv;
                                tos = top + 1;
                            end
                        IO_HALT: halt_q = 1;
                        default: ;
                    endcase
                CMD_LDA:
                    if (!walk(lev, b)) flt = 1;
                    else
                    begin
                        addr = b + sx(mem[top]);
                        if (addr < 0 || addr > top) flt = 1;
                        else mem[top] = mem[addr];
                    end
                CMD_STA:
                    if (top < 2 || !walk(lev, b)) flt = 1;
                    else
                    begin
                        addr = b + sx(mem[top - 1]);
                        if (addr < 0 || addr > top) flt = 1;
                        else
                        begin
                            mem[addr] = mem[top];
                            tos = top - 2;
                        end
                    end
                CMD_DEC:
                    if (!ok(top - m)) flt = 1;
                    else tos = top - m;
                default: ;
            endcase
            if (flt)
            begin
                halt_q = 1;
                err_q  = code;
            end
            else
                pc = npc;
        end
        st.next_pc    = pc;
        st.halted     = halt_q;
        st.fault_code = err_q;
        status_q.push_back(st);
    endtask

    initial
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
            mem[i] = '0;
        tos     = 0;
        fp_q    = 1;
        pc      = '0;
        halt_q  = 0;
        err_q   = ERR_NONE;
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[51:0];
                if (status_q.size() == 0)
                begin
                    $error("unexpected result item %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (got.next_pc !== want.next_pc)
                    begin
                        $error("next_pc exp %h got %h", want.next_pc, got.next_pc);
                        errors++;
                    end
                    if (got.write_valid !== want.write_valid)
                    begin
                        $error("write_valid exp %b got %b", want.write_valid,
                               got.write_valid);
                        errors++;
                    end
                    if (got.write_value !== want.write_value)
                    begin
                        $error("write_value exp %h got %h", want.write_value,
                               got.write_value);
                        errors++;
                    end
                    if (got.halted !== want.halted)
                    begin
                        $error("halted exp %b got %b", want.halted, got.halted);
                        errors++;
                    end
                    if (got.fault_code !== want.fault_code)
                    begin
                        $error("fault_code exp %0d got %0d", want.fault_code,
                               got.fault_code);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                exec_instr(s_tdata);
            pending = status_q.size();
        end
    end

endmodule

// ===== tb/sv/pl0_stack_machine_tb.sv =====
`timescale 1ns / 100ps

module pl0_stack_machine_tb;
    import p0sm_pkg::*;

    localparam int WDOG_LIMIT = 6000;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               errors;
    int               pending;
    int               items;
    int               idle_cycles;
    int               stall_left;
    bit               busy_mode;

    pl0_stack_machine u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pl0_stack_machine_chk u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap();
        int p;
        if (busy_mode)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    // sender: valid stays high across back-to-back items
    task automatic send(input cmd_t cmd, input logic [7:0] lev, input logic [31:0] opnd,
                        input logic [31:0] rdv = $urandom);
        int gap;
        bit hit;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, rdv, opnd, lev, 4'(cmd)};
        do
        begin
            @(negedge clk);
            hit = s_tready;
            @(posedge clk);
        end
        while (!hit);
        items++;
        if ($urandom_range(0, 49) == 0)
            busy_mode = !busy_mode;
    endtask

    task automatic send_raw(input logic [3:0] cmd, input logic [31:0] opnd);
        int gap;
        bit hit;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, 32'($urandom), opnd, 8'($urandom), cmd};
        do
        begin
            @(negedge clk);
            hit = s_tready;
            @(posedge clk);
        end
        while (!hit);
        items++;
    endtask

    task automatic binop(input logic [31:0] a, input logic [31:0] b, input logic [31:0] op);
        longint r;
        r = longint'($signed(a));
        if (op == OPR_ADD)
            r = r + longint'($signed(b));
        else
            r = r * longint'($signed(b));
        if ((op == OPR_ADD || op == OPR_MUL) &&
            (r < -64'sd2147483648 || r > 64'sd2147483647))
            b = (op == OPR_ADD) ? 32'd0 : 32'd1;
        if ((op == OPR_DIV || op == OPR_MOD) && b == 0)
            b = 32'd1;
        send(CMD_LIT, $urandom, a);
        send(CMD_LIT, $urandom, b);
        send(CMD_OPR, $urandom, op);
        send(CMD_SIO, $urandom, IO_WRITE);
    endtask

    // frame body: called from fp = 1, so the frame's static link points at 1
    task automatic call_seq();
        logic [7:0] lv;
        send(CMD_CAL, 8'd0, $urandom);
        send(CMD_INC, $urandom, 32'd4);
        lv = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 3));
        send(CMD_LOD, lv, $urandom_range(4, 20));
        send(CMD_SIO, $urandom, IO_WRITE);
        send(CMD_LIT, $urandom, rnd32());
        send(CMD_STO, $urandom_range(0, 255), $urandom_range(4, 20));
        send(CMD_LIT, $urandom, $urandom_range(0, 4));
        send(CMD_LDA, $urandom_range(0, 255), 32'($urandom));
        send(CMD_SIO, $urandom, IO_WRITE);
        send(CMD_LIT, $urandom, ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(4, 5)));
        send(CMD_LIT, $urandom, rnd32());
        send(CMD_STA, $urandom_range(0, 255), 32'($urandom));
        if ($urandom_range(0, 1))
        begin
            send(CMD_CAL, $urandom_range(0, 255), $urandom);
            send(CMD_INC, $urandom, 32'd4);
            send(CMD_OPR, $urandom, OPR_RET);
        end
        send(CMD_OPR, $urandom, OPR_RET);
    endtask

    task automatic random_seq();
        logic [31:0] v;
        logic [31:0] n;
        case ($urandom_range(0, 9))
            0, 1: binop(rnd32(), rnd32(), $urandom_range(2, 13) == 6 ? OPR_ADD :
                        32'($urandom_range(2, 13)));
            2:
            begin
                send(CMD_LIT, $urandom, rnd32());
                send(CMD_OPR, $urandom, $urandom_range(0, 1) ? OPR_NEG : OPR_ODD);
                send(CMD_SIO, $urandom, IO_WRITE);
            end
            3:
            begin
                send(CMD_LIT, $urandom, rnd32());
                send(CMD_STO, 8'd0, $urandom_range(4, 20));
                send(CMD_LOD, 8'd0, $urandom_range(4, 20));
                send(CMD_SIO, $urandom, IO_WRITE);
            end
            4:
            begin
                send(CMD_SIO, $urandom, IO_READ, rnd32());
                send(CMD_SIO, $urandom, IO_WRITE);
            end
            5:
            begin
                v = $urandom_range(0, 1) ? 32'd0 : rnd32();
                send(CMD_JMP, $urandom, $urandom);
                send(CMD_LIT, $urandom, v);
                send(CMD_JPC, $urandom, $urandom);
            end
            6:
            begin
                n = $urandom_range(0, 1023);
                if ($urandom_range(0, 1))
                begin
                    send(CMD_INC, $urandom, n);
                    send(CMD_DEC, $urandom, n);
                end
                else
                begin
                    send(CMD_DEC, $urandom, -n);
                    send(CMD_INC, $urandom, -n);
                end
            end
            7: call_seq();
            default:
                case ($urandom_range(0, 2))
                    0: send_raw(4'($urandom_range(12, 15)), $urandom);
                    1: send(CMD_OPR, $urandom, $urandom_range(0, 1) ?
                            32'($urandom_range(14, 1000)) : 32'($urandom) | 32'h8000_0000);
                    default: send(CMD_SIO, $urandom, $urandom_range(0, 1) ?
                                  32'($urandom_range(3, 1000)) : 32'($urandom) | 32'h8000_0000);
                endcase
        endcase
    endtask

    task automatic finish_seq();
        case ($urandom_range(0, 6))
            0: send(CMD_SIO, $urandom, IO_WRITE);
            1:
            begin
                send(CMD_LIT, $urandom, 32'd5);
                send(CMD_LIT, $urandom, 32'd0);
                send(CMD_OPR, $urandom, $urandom_range(0, 1) ? OPR_DIV : OPR_MOD);
            end
            2:
            begin
                send(CMD_LIT, $urandom, 32'h7fff_ffff);
                send(CMD_LIT, $urandom, 32'd1);
                send(CMD_OPR, $urandom, OPR_ADD);
            end
            3:
            begin
                send(CMD_LIT, $urandom, 32'h0001_0000);
                send(CMD_LIT, $urandom, 32'h0001_0000);
                send(CMD_OPR, $urandom, OPR_MUL);
            end
            4: send(CMD_SIO, $urandom, IO_HALT);
            5:
            begin
                send(CMD_LIT, $urandom, 32'd0);
                send(CMD_STO, 8'd0, 32'd2);
                send(CMD_OPR, $urandom, OPR_RET);
            end
            default: send(CMD_DEC, $urandom, 32'd1);
        endcase
        repeat (3) send(cmd_t'($urandom_range(0, 11)), $urandom, rnd32());
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || busy_mode)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:       stall_left <= $urandom_range(10, 40);
                1, 2, 3: stall_left <= $urandom_range(1, 3);
                default: ;
            endcase
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        stall_left  = 0;
        busy_mode   = 0;
        items       = 0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        binop(32'h7fff_ffff, 32'h8000_0000, OPR_SUB);
        binop(32'h8000_0000, 32'hffff_ffff, OPR_DIV);
        binop(32'h8000_0000, 32'hffff_ffff, OPR_MOD);
        binop(32'hffff_fff9, 32'd2, OPR_MOD);
        send(CMD_LIT, 8'hff, 32'h8000_0000);
        send(CMD_OPR, 8'h00, OPR_NEG);
        send(CMD_OPR, 8'h00, OPR_ODD);
        send(CMD_SIO, 8'h00, IO_WRITE);
        send(CMD_SIO, 8'h00, IO_READ, 32'hffff_ffff);
        send(CMD_JPC, 8'h00, 32'hffff_ffff);
        send(CMD_LIT, 8'h00, 32'd0);
        send(CMD_JPC, 8'h00, 32'h1234_5678);
        send(CMD_INC, 8'h00, 32'd1023);
        send(CMD_DEC, 8'h00, 32'd1023);
        send_raw(4'd15, 32'hffff_ffff);
        call_seq();

        while (items < 200)
            random_seq();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        while (items < 400)
            random_seq();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (50) @(posedge clk);
        finish_seq();
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== pl0_stack_machine.f =====
hdl/p0sm_pkg.sv
hdl/p0sm_ram.sv
hdl/p0sm_div.sv
hdl/pl0_stack_machine.sv
tb/sv/pl0_stack_machine_chk.sv
tb/sv/pl0_stack_machine_tb.sv
